FILE: rtl/fdcss_pkg.sv
// Shared types, codes and defaults for the floppy controller soft switch block.
package fdcss_pkg;

   // Default sizes
   localparam int TRACK_BYTES_DEF    = 8192;
   localparam int MAX_HALF_TRACK_DEF = 79;

   // Field widths
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 14;
   localparam int TRACK_W     = 6;
   localparam int HALF_W      = 7;
   localparam int LENGTH_W    = 14;
   localparam int INDEX_W     = 13;

   // Commands
   localparam logic [1:0] CMD_BUS  = 2'd0;
   localparam logic [1:0] CMD_FILL = 2'd1;
   localparam logic [1:0] CMD_PEEK = 2'd2;

   // Soft switch nibbles above the stepper phases
   localparam logic [3:0] SW_MOTOR_OFF  = 4'd8;
   localparam logic [3:0] SW_MOTOR_ON   = 4'd9;
   localparam logic [3:0] SW_SEL_FIRST  = 4'd10;
   localparam logic [3:0] SW_SEL_SECOND = 4'd11;
   localparam logic [3:0] SW_LATCH      = 4'd12;
   localparam logic [3:0] SW_PROTECT    = 4'd13;
   localparam logic [3:0] SW_READ_MODE  = 4'd14;
   localparam logic [3:0] SW_WRITE_MODE = 4'd15;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_LENGTH   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTECT_FIRST  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PROTECT_SECOND = 2'd3;

   // Register reset values
   localparam logic [TRACK_W-1:0]  TRACK_COUNT_RST  = 6'd35;
   localparam logic [LENGTH_W-1:0] TRACK_LENGTH_RST = 14'd6656;

   // Latch masks
   localparam logic [7:0] PROTECT_BIT = 8'h80;
   localparam logic [7:0] DATA_MASK   = 8'h7f;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         switch_addr;
      logic               is_write;
      logic [7:0]         bus_data;
      logic               store_drive;
      logic [INDEX_W-1:0] store_index;
      logic [7:0]         store_value;
   } req_type;

   typedef struct packed {
      logic [7:0]         read_data;
      logic               track_changed;
      logic               flush_needed;
      logic [TRACK_W-1:0] old_track;
      logic [TRACK_W-1:0] dest_track;
      logic               changed_drive;
      logic [7:0]         peek_value;
   } rsp_type;

endpackage

FILE: rtl/fdcss_ram.sv
// Generic single-port synchronous RAM with registered read data.
module fdcss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write or read one entry; read data holds while idle
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/floppy_disk_controller_soft_switches.sv
// Top level: two-drive floppy controller behind sixteen soft switches.
// A request goes through a stage register (store access) and then the result register.
// Throughput: one request per cycle while the receiver does not stall; the track store
// RAM port is used at most once per item and a latch read that waits on the RAM output
// is forwarded to the following item. Reset (synchronous, active high) clears drive
// state, registers and valids; the track store is not cleared and holds undefined data
// until filled. TRACK_BYTES must be a power of two; the block does not enforce it.
module floppy_disk_controller_soft_switches #(
   parameter int TRACK_BYTES    = fdcss_pkg::TRACK_BYTES_DEF,
   parameter int MAX_HALF_TRACK = fdcss_pkg::MAX_HALF_TRACK_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  fdcss_pkg::req_type                  req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output fdcss_pkg::rsp_type                  rsp_payload,
   input  logic                                csr_wr_en,
   input  logic [fdcss_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fdcss_pkg::CSR_DATA_W-1:0]    csr_wr_data
);
   import fdcss_pkg::*;

   localparam int AW = $clog2(TRACK_BYTES);
   localparam int LW = AW + 1;
   localparam int IW = (AW > INDEX_W) ? AW : INDEX_W;
   localparam int TW = (LW > LENGTH_W) ? LW : LENGTH_W;

   // Item in flight between the RAM access and the output register
   typedef struct packed {
      logic [7:0]         rd;
      logic               rd_ram;
      logic               pk_ram;
      logic               load_latch;
      logic               drive;
      logic               chg;
      logic               fl;
      logic [TRACK_W-1:0] ot;
      logic [TRACK_W-1:0] nt;
      logic               cd;
   } stage_type;

   // Configuration
   logic [TRACK_W-1:0]  track_count_ff, track_count_in;
   logic [LENGTH_W-1:0] track_length_ff, track_length_in;
   logic                protect_first_ff, protect_first_in;
   logic                protect_second_ff, protect_second_in;

   // Drive state
   logic               sel_drive_ff, sel_drive_in;
   logic [3:0]         phase_ff [2];
   logic [3:0]         phase_in [2];
   logic [HALF_W-1:0]  half_ff [2];
   logic [HALF_W-1:0]  half_in [2];
   logic [TRACK_W-1:0] track_ff [2];
   logic [TRACK_W-1:0] track_in [2];
   logic               wmode_ff [2];
   logic               wmode_in [2];
   logic               dirty_ff [2];
   logic               dirty_in [2];
   logic [7:0]         latch_ff [2];
   logic [7:0]         latch_in [2];
   logic [AW-1:0]      cursor_ff [2];
   logic [AW-1:0]      cursor_in [2];

   // Pipeline
   logic      s1_valid_ff, s1_valid_in;
   stage_type s1_ff, s1_in;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff, rsp_in;

   // Track store port
   logic          ram_en;
   logic          ram_we;
   logic [AW:0]   ram_addr;
   logic [7:0]    ram_wdata;
   logic [7:0]    ram_rdata;

   logic          req_fire;
   logic          s1_adv;
   logic [7:0]    latch_fwd [2];
   logic [LW-1:0] eff_len;

   fdcss_ram #(
      .WIDTH (8),
      .DEPTH (2 * TRACK_BYTES)
   ) u_store (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Handshake
   assign s1_adv    = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Forward a latch load still sitting on the RAM output
   assign latch_fwd[0] = (s1_valid_ff && s1_ff.load_latch && !s1_ff.drive) ?
                         ram_rdata : latch_ff[0];
   assign latch_fwd[1] = (s1_valid_ff && s1_ff.load_latch && s1_ff.drive) ?
                         ram_rdata : latch_ff[1];

   // Clamp the track length to 1..TRACK_BYTES
   always_comb begin
      logic [TW-1:0] tl;
      tl = TW'(track_length_ff);
      if (tl == '0) begin
         eff_len = LW'(1);
      end else if (tl > TW'(TRACK_BYTES)) begin
         eff_len = LW'(TRACK_BYTES);
      end else begin
         eff_len = tl[LW-1:0];
      end
   end

   // Configuration writes
   always_comb begin
      track_count_in    = track_count_ff;
      track_length_in   = track_length_ff;
      protect_first_in  = protect_first_ff;
      protect_second_in = protect_second_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TRACK_COUNT:    track_count_in    = csr_wr_data[TRACK_W-1:0];
            CSR_TRACK_LENGTH:   track_length_in   = csr_wr_data[LENGTH_W-1:0];
            CSR_PROTECT_FIRST:  protect_first_in  = csr_wr_data[0];
            CSR_PROTECT_SECOND: protect_second_in = csr_wr_data[0];
         endcase
      end
   end

   // Decode one request, update drive state and drive the store port
   always_comb begin
      logic               d;
      logic [3:0]         ph;
      logic [HALF_W-1:0]  ht;
      logic [HALF_W-1:0]  ht_n;
      logic               up;
      logic               down;
      logic [TRACK_W-1:0] lim;
      logic [TRACK_W-1:0] t;
      logic [AW:0]        cur_n;
      logic [IW-1:0]      idx_wide;
      logic [AW-1:0]      idx;
      logic               prot;

      sel_drive_in = sel_drive_ff;
      phase_in     = phase_ff;
      half_in      = half_ff;
      track_in     = track_ff;
      wmode_in     = wmode_ff;
      dirty_in     = dirty_ff;
      latch_in     = latch_fwd;
      cursor_in    = cursor_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = '0;
      ram_wdata    = '0;
      s1_in        = s1_ff;
      s1_valid_in  = s1_valid_ff;

      d        = sel_drive_ff;
      ph       = phase_ff[d];
      ht       = half_ff[d];
      ht_n     = ht;
      up       = 1'b0;
      down     = 1'b0;
      lim      = '0;
      t        = '0;
      cur_n    = '0;
      idx_wide = IW'(req_payload.store_index);
      idx      = idx_wide[AW-1:0];
      prot     = d ? protect_second_ff : protect_first_ff;

      // Retire the stage when the output register takes it
      if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      if (req_fire) begin
         s1_valid_in = 1'b1;
         s1_in       = '0;
         s1_in.drive = d;
         unique case (req_payload.cmd)
            CMD_FILL: begin
               ram_en    = 1'b1;
               ram_we    = 1'b1;
               ram_addr  = {req_payload.store_drive, idx};
               ram_wdata = req_payload.store_value;
            end
            CMD_PEEK: begin
               ram_en       = 1'b1;
               ram_addr     = {req_payload.store_drive, idx};
               s1_in.pk_ram = 1'b1;
            end
            CMD_BUS: begin
               if (!req_payload.switch_addr[3]) begin
                  // Stepper phase switch, then at most one half-track step
                  if (req_payload.switch_addr[0]) begin
                     ph = ph | (4'b0001 << req_payload.switch_addr[2:1]);
                  end else begin
                     ph = ph & ~(4'b0001 << req_payload.switch_addr[2:1]);
                  end
                  phase_in[d] = ph;
                  up   = ph[ht[1:0] + 2'd1];
                  down = ph[ht[1:0] + 2'd3];
                  if (down) begin
                     if (ht != '0) ht_n = ht - HALF_W'(1);
                  end else if (up) begin
                     if (ht < HALF_W'(MAX_HALF_TRACK)) ht_n = ht + HALF_W'(1);
                  end
                  half_in[d] = ht_n;
                  lim = (track_count_ff == '0) ? '0 : track_count_ff - TRACK_W'(1);
                  t   = ht_n[HALF_W-1:1];
                  if (t > lim) t = lim;
                  if ((up || down) && (t != track_ff[d])) begin
                     s1_in.chg    = 1'b1;
                     s1_in.fl     = dirty_ff[d];
                     s1_in.ot     = track_ff[d];
                     s1_in.nt     = t;
                     s1_in.cd     = d;
                     track_in[d]  = t;
                     dirty_in[d]  = 1'b0;
                     cursor_in[d] = '0;
                  end
               end else begin
                  unique case (req_payload.switch_addr)
                     SW_SEL_FIRST, SW_SEL_SECOND: begin
                        sel_drive_in = req_payload.switch_addr[0];
                     end
                     SW_LATCH: begin
                        // Move one nibble and advance the cursor
                        ram_en   = 1'b1;
                        ram_addr = {d, cursor_ff[d]};
                        if (wmode_ff[d]) begin
                           ram_we      = 1'b1;
                           ram_wdata   = latch_fwd[d];
                           dirty_in[d] = 1'b1;
                        end else begin
                           s1_in.rd_ram     = 1'b1;
                           s1_in.load_latch = !req_payload.is_write;
                        end
                        cur_n = {1'b0, cursor_ff[d]} + LW'(1);
                        cursor_in[d] = (cur_n >= eff_len) ? '0 : cur_n[AW-1:0];
                     end
                     SW_PROTECT: begin
                        latch_in[d] = prot ? (latch_fwd[d] | PROTECT_BIT) :
                                             (latch_fwd[d] & DATA_MASK);
                     end
                     SW_READ_MODE:  wmode_in[d] = 1'b0;
                     SW_WRITE_MODE: wmode_in[d] = 1'b1;
                     default: begin
                        // Motor switches leave no trace in the results
                     end
                  endcase
               end
               // Even switches return the latch, then a bus write loads it
               if (!req_payload.switch_addr[0]) begin
                  s1_in.rd = latch_in[sel_drive_in];
               end
               if (req_payload.is_write) begin
                  latch_in[sel_drive_in] = req_payload.bus_data;
               end
            end
            default: begin
               // Unknown command: all-zero result
            end
         endcase
      end
   end

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (s1_adv) begin
         rsp_valid_in         = s1_valid_ff;
         rsp_in.read_data     = s1_ff.rd_ram ? ram_rdata : s1_ff.rd;
         rsp_in.track_changed = s1_ff.chg;
         rsp_in.flush_needed  = s1_ff.fl;
         rsp_in.old_track     = s1_ff.ot;
         rsp_in.dest_track    = s1_ff.nt;
         rsp_in.changed_drive = s1_ff.cd;
         rsp_in.peek_value    = s1_ff.pk_ram ? ram_rdata : 8'd0;
      end
   end

   // Control and drive state
   always_ff @(posedge clock) begin
      if (reset) begin
         track_count_ff    <= TRACK_COUNT_RST;
         track_length_ff   <= TRACK_LENGTH_RST;
         protect_first_ff  <= 1'b0;
         protect_second_ff <= 1'b0;
         sel_drive_ff      <= 1'b0;
         phase_ff          <= '{default: '0};
         half_ff           <= '{default: '0};
         track_ff          <= '{default: '0};
         wmode_ff          <= '{default: 1'b0};
         dirty_ff          <= '{default: 1'b0};
         latch_ff          <= '{default: '0};
         cursor_ff         <= '{default: '0};
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         track_count_ff    <= track_count_in;
         track_length_ff   <= track_length_in;
         protect_first_ff  <= protect_first_in;
         protect_second_ff <= protect_second_in;
         sel_drive_ff      <= sel_drive_in;
         phase_ff          <= phase_in;
         half_ff           <= half_in;
         track_ff          <= track_in;
         wmode_ff          <= wmode_in;
         dirty_ff          <= dirty_in;
         latch_ff          <= latch_in;
         cursor_ff         <= cursor_in;
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_ff  <= s1_in;
      rsp_ff <= rsp_in;
   end

   // Head position stays within range
   assert property (@(posedge clock) disable iff (reset)
      (half_ff[0] <= HALF_W'(MAX_HALF_TRACK)) && (half_ff[1] <= HALF_W'(MAX_HALF_TRACK)))
      else $error("half-track beyond limit");

   // Track never lies beyond the half-track position
   assert property (@(posedge clock) disable iff (reset)
      (track_ff[0] <= half_ff[0][HALF_W-1:1]) && (track_ff[1] <= half_ff[1][HALF_W-1:1]))
      else $error("track ahead of head position");

   // A reported change names two different tracks
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.track_changed |-> rsp_ff.old_track != rsp_ff.dest_track)
      else $error("track change without new track");

   // No change data without a change
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.track_changed |->
         !rsp_ff.flush_needed && (rsp_ff.old_track == '0) && (rsp_ff.dest_track == '0)
         && !rsp_ff.changed_drive)
      else $error("stray track change data");

endmodule

FILE: sim/tb_floppy_disk_controller_soft_switches.sv
`timescale 1ns / 100ps
// Self-checking testbench for the two-drive floppy controller soft switch block.
module tb_floppy_disk_controller_soft_switches;
   import fdcss_pkg::*;

   // Command code the block must ignore
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_wr_en   = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_wr_data = '0;

   floppy_disk_controller_soft_switches u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Controller image: configuration
   logic [TRACK_W-1:0]  cfg_tracks  = TRACK_COUNT_RST;
   logic [LENGTH_W-1:0] cfg_length  = TRACK_LENGTH_RST;
   logic                cfg_protect [2] = '{default: 1'b0};

   // Controller image: per-drive state and track stores
   logic                sel_drv = 1'b0;
   logic [3:0]          phase_on [2] = '{default: '0};
   logic [HALF_W-1:0]   half_pos [2] = '{default: '0};
   logic [TRACK_W-1:0]  trk      [2] = '{default: '0};
   logic                motor_on [2] = '{default: 1'b0};
   logic                wmode    [2] = '{default: 1'b0};
   logic                dirty    [2] = '{default: 1'b0};
   logic [7:0]          latch_q  [2] = '{default: '0};
   logic [INDEX_W-1:0]  cur      [2] = '{default: '0};
   bit   [7:0]          nib_store  [0:2*TRACK_BYTES_DEF-1];
   bit                  nib_filled [0:2*TRACK_BYTES_DEF-1];

   rsp_type owed_results [$];

   int n_errors = 0;
   int n_beats = 0;
   int n_moves = 0;
   int n_flushes = 0;
   int n_latch = 0;
   int n_fills = 0;
   int n_peeks = 0;
   int n_csr = 0;

   int burst_left = 0;
   bit no_gaps = 1'b0;
   int hold_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Advance the controller image by one request and return the result it owes
   function automatic rsp_type soft_switch_result(input req_type r);
      rsp_type      res;
      logic         d;
      logic [13:0]  pos;
      int           hp, t, lim, eff, step;
      res = '0;
      d = sel_drv;
      case (r.cmd)
         CMD_FILL: begin
            pos = {r.store_drive, r.store_index};
            nib_store[pos] = r.store_value;
            nib_filled[pos] = 1'b1;
            n_fills++;
         end
         CMD_PEEK: begin
            res.peek_value = nib_store[{r.store_drive, r.store_index}];
            n_peeks++;
         end
         CMD_BUS: begin
            case (r.switch_addr)
               SW_MOTOR_OFF, SW_MOTOR_ON: motor_on[d] = r.switch_addr[0];
               SW_SEL_FIRST, SW_SEL_SECOND: sel_drv = r.switch_addr[0];
               SW_LATCH: begin
                  pos = {d, cur[d]};
                  if (wmode[d]) begin
                     nib_store[pos] = latch_q[d];
                     nib_filled[pos] = 1'b1;
                     dirty[d] = 1'b1;
                  end else begin
                     latch_q[d] = nib_store[pos];
                  end
                  eff = (cfg_length == 0) ? 1 :
                        (cfg_length > TRACK_BYTES_DEF) ? TRACK_BYTES_DEF : int'(cfg_length);
                  if (int'(cur[d]) + 1 >= eff) cur[d] = '0;
                  else cur[d] = cur[d] + 1'b1;
                  n_latch++;
               end
               SW_PROTECT: latch_q[d][7] = cfg_protect[d];
               SW_READ_MODE: wmode[d] = 1'b0;
               SW_WRITE_MODE: wmode[d] = 1'b1;
               default: begin
                  // stepper phase on or off, then pull the head at most one half-track
                  phase_on[d][r.switch_addr[2:1]] = r.switch_addr[0];
                  hp = int'(half_pos[d]);
                  step = 0;
                  if (phase_on[d][2'(hp + 1)]) step = 1;
                  if (phase_on[d][2'(hp + 3)]) step = -1;
                  if (step != 0) begin
                     lim = (cfg_tracks == 0) ? 0 : int'(cfg_tracks) - 1;
                     if (step > 0 && hp < MAX_HALF_TRACK_DEF) hp++;
                     if (step < 0 && hp > 0) hp--;
                     half_pos[d] = HALF_W'(hp);
                     t = hp / 2;
                     if (t > lim) t = lim;
                     if (t != int'(trk[d])) begin
                        res.track_changed = 1'b1;
                        res.flush_needed = dirty[d];
                        res.old_track = trk[d];
                        res.dest_track = TRACK_W'(t);
                        res.changed_drive = d;
                        n_moves++;
                        if (dirty[d]) n_flushes++;
                        trk[d] = TRACK_W'(t);
                        dirty[d] = 1'b0;
                        cur[d] = '0;
                     end
                  end
               end
            endcase
            d = sel_drv;
            if (!r.switch_addr[0]) res.read_data = latch_q[d];
            if (r.is_write) latch_q[d] = r.bus_data;
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic req_type rand_req();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return req_type'(bits[$bits(req_type)-1:0]);
   endfunction

   function automatic req_type bus_req(input logic [3:0] addr);
      req_type r;
      r = rand_req();
      r.cmd = CMD_BUS;
      r.switch_addr = addr;
      r.is_write = ($urandom_range(0, 3) == 0);
      return r;
   endfunction

   function automatic req_type fill_req(input logic drv, input logic [12:0] idx,
                                        input logic [7:0] val);
      req_type r;
      r = rand_req();
      r.cmd = CMD_FILL;
      r.store_drive = drv;
      r.store_index = idx;
      r.store_value = val;
      return r;
   endfunction

   function automatic req_type peek_req(input logic drv, input logic [12:0] idx);
      req_type r;
      r = rand_req();
      r.cmd = CMD_PEEK;
      r.store_drive = drv;
      r.store_index = idx;
      return r;
   endfunction

   // Soft switch nibble for one stepper phase
   function automatic logic [3:0] phase_switch(input int ph, input logic on);
      return {1'b0, 2'(ph), on};
   endfunction

   // Offer one request beat in bursts with random gaps; predict on acceptance
   task automatic offer_beat(input req_type r);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         if (!no_gaps && $urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      owed_results.push_back(soft_switch_result(r));
      n_beats++;
   endtask

   // Fill a store entry first whenever the request would read it unwritten
   task automatic send_item(input req_type r);
      logic [13:0] pos;
      logic        need;
      need = 1'b0;
      pos = '0;
      if (r.cmd == CMD_PEEK) begin
         pos = {r.store_drive, r.store_index};
         need = !nib_filled[pos];
      end else if (r.cmd == CMD_BUS && r.switch_addr == SW_LATCH && !wmode[sel_drv]) begin
         pos = {sel_drv, cur[sel_drv]};
         need = !nib_filled[pos];
      end
      if (need) offer_beat(fill_req(pos[13], pos[12:0], 8'($urandom)));
      offer_beat(r);
   endtask

   // Drop valid and hold until every owed result has come back
   task automatic drain();
      req_valid <= 1'b0;
      burst_left = 0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_reg(input logic [CSR_INDEX_W-1:0] idx,
                          input logic [CSR_DATA_W-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      case (idx)
         CSR_TRACK_COUNT:    cfg_tracks = value[TRACK_W-1:0];
         CSR_TRACK_LENGTH:   cfg_length = value[LENGTH_W-1:0];
         CSR_PROTECT_FIRST:  cfg_protect[0] = value[0];
         CSR_PROTECT_SECOND: cfg_protect[1] = value[0];
         default: ;
      endcase
      n_csr++;
   endtask

   // Walk the selected head one half-track per step with clean phase sequences
   task automatic seek(input int dir, input int steps);
      int from;
      from = int'(half_pos[sel_drv]) % 4;
      for (int p = 0; p < 4; p++)
         if (p != from && phase_on[sel_drv][p]) send_item(bus_req(phase_switch(p, 1'b0)));
      repeat (steps) begin
         from = int'(half_pos[sel_drv]) % 4;
         send_item(bus_req(phase_switch((from + 4 + dir) % 4, 1'b1)));
         send_item(bus_req(phase_switch(from, 1'b0)));
      end
   endtask

   // Field extremes, unknown command, every soft switch once
   task automatic test_directed();
      req_type r;
      r = rand_req();
      r.cmd = CMD_UNKNOWN;
      send_item(r);
      send_item(fill_req(1'b0, 13'd0, 8'hff));
      send_item(fill_req(1'b1, 13'h1fff, 8'h00));
      send_item(fill_req(1'b0, 13'h1fff, 8'ha5));
      send_item(fill_req(1'b1, 13'd0, 8'h5a));
      send_item(peek_req(1'b0, 13'd0));
      send_item(peek_req(1'b1, 13'h1fff));
      send_item(peek_req(1'b0, 13'h1fff));
      send_item(peek_req(1'b1, 13'd0));
      for (int a = 0; a < 16; a++) begin
         r = bus_req(4'(a));
         r.is_write = a[1];
         r.bus_data = a[2] ? 8'hff : 8'h00;
         send_item(r);
      end
   endtask

   // Write-protect sense on each drive under both protect settings
   task automatic test_protect();
      for (int k = 0; k < 2; k++) begin
         set_reg(CSR_PROTECT_FIRST, CSR_DATA_W'(k == 0));
         set_reg(CSR_PROTECT_SECOND, CSR_DATA_W'(k == 1));
         send_item(bus_req(SW_SEL_FIRST));
         send_item(bus_req(SW_PROTECT));
         send_item(bus_req(SW_READ_MODE));
         send_item(bus_req(SW_SEL_SECOND));
         send_item(bus_req(SW_PROTECT));
         send_item(bus_req(SW_READ_MODE));
      end
   endtask

   // Cursor wrap at short, zero, oversized and shrunk track lengths
   task automatic test_cursor();
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(5));
      send_item(bus_req(SW_WRITE_MODE));
      repeat (7) send_item(bus_req(SW_LATCH));
      send_item(bus_req(SW_READ_MODE));
      repeat (6) send_item(bus_req(SW_LATCH));
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(0));
      repeat (3) send_item(bus_req(SW_LATCH));
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(16383));
      repeat (3) send_item(bus_req(SW_LATCH));
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(8192));
      repeat (3) send_item(bus_req(SW_LATCH));
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(40));
      repeat (12) send_item(bus_req(SW_LATCH));
      // shrink below the cursor: the next access still uses it, then wraps
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(4));
      repeat (3) send_item(bus_req(SW_LATCH));
      set_reg(CSR_TRACK_LENGTH, CSR_DATA_W'(1));
      repeat (3) send_item(bus_req(SW_LATCH));
   endtask

   // Full head sweeps, clamps, track limits and flush on a dirty track
   task automatic test_seek();
      set_reg(CSR_TRACK_COUNT, CSR_DATA_W'(40));
      send_item(bus_req(SW_SEL_FIRST));
      send_item(bus_req(SW_WRITE_MODE));
      repeat (3) send_item(bus_req(SW_LATCH));
      send_item(bus_req(SW_READ_MODE));
      seek(1, 82);
      send_item(bus_req(SW_WRITE_MODE));
      send_item(bus_req(SW_LATCH));
      seek(-1, 82);
      set_reg(CSR_TRACK_COUNT, CSR_DATA_W'(1));
      seek(1, 6);
      seek(-1, 6);
      set_reg(CSR_TRACK_COUNT, CSR_DATA_W'(0));
      seek(1, 6);
      seek(-1, 6);
      set_reg(CSR_TRACK_COUNT, CSR_DATA_W'(63));
      send_item(bus_req(SW_SEL_SECOND));
      seek(1, 20);
      // lower the limit under the current track, then step
      set_reg(CSR_TRACK_COUNT, CSR_DATA_W'(5));
      seek(-1, 3);
      seek(-1, 24);
      set_reg(CSR_TRACK_COUNT, CSR_DATA_W'(35));
   endtask

   // Long receiver hold-off while requests keep coming
   task automatic test_backpressure();
      drain();
      no_gaps = 1'b1;
      hold_cycles = 80;
      repeat (30) send_item(bus_req(4'($urandom_range(8, 15))));
      no_gaps = 1'b0;
      drain();
   endtask

   // Random phases under random settings, mostly well-formed sequences
   task automatic test_random();
      int start, pick, dir;
      logic [CSR_DATA_W-1:0] tc, tl;
      repeat (4) begin
         case ($urandom_range(0, 5))
            0: tc = CSR_DATA_W'(0);
            1: tc = CSR_DATA_W'(1);
            2: tc = CSR_DATA_W'(40);
            3: tc = CSR_DATA_W'(63);
            default: tc = CSR_DATA_W'($urandom_range(2, 39));
         endcase
         case ($urandom_range(0, 7))
            0: tl = CSR_DATA_W'(0);
            1: tl = CSR_DATA_W'(1);
            2: tl = CSR_DATA_W'(8192);
            3: tl = CSR_DATA_W'(16383);
            4: tl = CSR_DATA_W'(6656);
            default: tl = CSR_DATA_W'($urandom_range(2, 48));
         endcase
         set_reg(CSR_TRACK_COUNT, tc);
         set_reg(CSR_TRACK_LENGTH, tl);
         set_reg(CSR_PROTECT_FIRST, CSR_DATA_W'($urandom_range(0, 1)));
         set_reg(CSR_PROTECT_SECOND, CSR_DATA_W'($urandom_range(0, 1)));
         start = n_beats;
         while (n_beats - start < 75) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               if (half_pos[sel_drv] > 70) dir = -1;
               else if (half_pos[sel_drv] < 8) dir = 1;
               else dir = $urandom_range(0, 1) ? 1 : -1;
               seek(dir, $urandom_range(1, 20));
            end else if (pick < 55) begin
               send_item(bus_req($urandom_range(0, 9) < 4 ? SW_WRITE_MODE : SW_READ_MODE));
               repeat ($urandom_range(1, 12))
                  send_item(bus_req($urandom_range(0, 7) == 0 ? SW_PROTECT : SW_LATCH));
            end else if (pick < 70) begin
               repeat ($urandom_range(1, 6)) begin
                  tl = ($urandom_range(0, 3) == 0) ? CSR_DATA_W'($urandom_range(0, 8191))
                                                    : CSR_DATA_W'($urandom_range(0, 63));
                  if ($urandom_range(0, 1))
                     send_item(fill_req(1'($urandom), tl[12:0], 8'($urandom)));
                  else
                     send_item(peek_req(1'($urandom), tl[12:0]));
               end
            end else if (pick < 80) begin
               send_item(bus_req(4'($urandom_range(8, 11))));
            end else begin
               send_item(rand_req());
            end
         end
      end
   endtask

   // Receiver stall pattern, with a counted hold-off on request
   initial begin : rsp_stall_gen
      int mode, left, tick;
      mode = 0;
      left = 0;
      tick = 0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_stall <= 1'b1;
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 2);
               left = $urandom_range(16, 96);
            end
            left--;
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 99) < 40);
               default: rsp_stall <= (tick % 3 == 0);
            endcase
         end
      end
   end

   task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         n_errors++;
         if (n_errors <= 40)
            $display("%0t: %s expected %h got %h", $time, name, want, got);
      end
   endtask

   // Compare each result beat with the oldest owed result
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_results.size() == 0) begin
            n_errors++;
            if (n_errors <= 40)
               $display("%0t: result beat with none owed, expected nothing got %h",
                        $time, rsp_payload);
         end else begin
            want = owed_results.pop_front();
            cmp_field("read_data", want.read_data, rsp_payload.read_data);
            cmp_field("track_changed", 8'(want.track_changed),
                      8'(rsp_payload.track_changed));
            cmp_field("flush_needed", 8'(want.flush_needed), 8'(rsp_payload.flush_needed));
            cmp_field("old_track", 8'(want.old_track), 8'(rsp_payload.old_track));
            cmp_field("dest_track", 8'(want.dest_track), 8'(rsp_payload.dest_track));
            cmp_field("changed_drive", 8'(want.changed_drive),
                      8'(rsp_payload.changed_drive));
            cmp_field("peek_value", want.peek_value, rsp_payload.peek_value);
         end
      end
   end

   initial begin
      #20000000;
      $display("%0t: run timed out with %0d results owed", $time, owed_results.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_protect();
      test_cursor();
      test_seek();
      test_backpressure();
      test_random();
      drain();
      $display("Covered %0d beats: %0d track changes (%0d needing a flush), %0d latch accesses",
               n_beats, n_moves, n_flushes, n_latch);
      $display("  plus %0d store fills, %0d peeks and %0d register writes",
               n_fills, n_peeks, n_csr);
      if (n_errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
